@@ rtl/assert_macros.svh @@
// assertion macros for the hash engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a on one edge implies b on the next
`define ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed: next-cycle implication");

// a implies b on the same edge
`define ASSERT_SAME(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed: same-cycle implication");

`endif

@@ rtl/skhe_pkg.sv @@
// shared types, constants and helpers of the key hash engine
package skhe_pkg;

   localparam logic [1:0] ALG_FNV    = 2'd0;
   localparam logic [1:0] ALG_DJB    = 2'd1;
   localparam logic [1:0] ALG_MURMUR = 2'd2;

   localparam logic [1:0] CSR_ALGORITHM = 2'd0;
   localparam logic [1:0] CSR_FOLD_CASE = 2'd1;

   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME = 32'd16777619;
   localparam logic [31:0] DJB_START = 32'd5381;
   localparam logic [31:0] MM_C1     = 32'hcc9e2d51;
   localparam logic [31:0] MM_C2     = 32'h1b873593;
   localparam logic [31:0] MM_N      = 32'he6546b64;
   localparam logic [31:0] MM_F1     = 32'h85ebca6b;
   localparam logic [31:0] MM_F2     = 32'hc2b2ae35;
   localparam logic [31:0] MM_H_MUL  = 32'd5;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_BYTE,
      OP_KMIX2,
      OP_HMIX,
      OP_TAIL1,
      OP_FMIX1,
      OP_FMIX2,
      OP_FIN
   } op_type;

   typedef struct packed {
      op_type op;
      logic   use_w;
   } cmd_type;

   typedef struct packed {
      logic murmur;
      logic blk_full;
   } status_type;

   function automatic logic [31:0] rotl15(input logic [31:0] v);
      rotl15 = {v[16:0], v[31:17]};
   endfunction

   function automatic logic [31:0] rotl13(input logic [31:0] v);
      rotl13 = {v[18:0], v[31:19]};
   endfunction

   function automatic logic [31:0] start_value(input logic [1:0] alg);
      case (alg)
         ALG_DJB:    start_value = DJB_START;
         ALG_MURMUR: start_value = 32'd0;
         default:    start_value = FNV_BASIS;
      endcase
   endfunction

endpackage

@@ rtl/skhe_ctrl.sv @@
// sequencing state machine of the key hash engine
module skhe_ctrl import skhe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_KMIX2 = 8'b0000_0010,
      ST_HMIX  = 8'b0000_0100,
      ST_TAIL1 = 8'b0000_1000,
      ST_TAIL2 = 8'b0001_0000,
      ST_FMIX1 = 8'b0010_0000,
      ST_FMIX2 = 8'b0100_0000,
      ST_FIN   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      last_ff, last_in;
   logic      tail_ff, tail_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      last_in      = last_ff;
      tail_in      = tail_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = OP_NONE;
      cmd.use_w    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.op  = OP_BYTE;
               last_in = req_last_byte;
               tail_in = 1'b0;
               if (status.murmur) begin
                  if (status.blk_full) begin
                     state_in = ST_KMIX2;
                  end else if (req_last_byte) begin
                     state_in = ST_TAIL1;
                     tail_in  = 1'b1;
                  end
               end else if (req_last_byte) begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_KMIX2: begin
            cmd.op   = OP_KMIX2;
            state_in = ST_HMIX;
         end
         ST_HMIX: begin
            cmd.op   = OP_HMIX;
            state_in = last_ff ? ST_FMIX1 : ST_IDLE;
         end
         ST_TAIL1: begin
            cmd.op   = OP_TAIL1;
            state_in = ST_TAIL2;
         end
         ST_TAIL2: begin
            cmd.op   = OP_KMIX2;
            state_in = ST_FMIX1;
         end
         ST_FMIX1: begin
            cmd.op    = OP_FMIX1;
            cmd.use_w = tail_ff;
            state_in  = ST_FMIX2;
         end
         ST_FMIX2: begin
            cmd.op   = OP_FMIX2;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.op       = OP_FIN;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_ff      <= 1'b0;
         tail_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ rtl/skhe_datapath.sv @@
// hash state, shared multiplier and result word of the key hash engine
module skhe_datapath import skhe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [1:0]  csr_data,
   input  logic [7:0]  req_key_byte,
   input  cmd_type     cmd,
   output status_type  status,
   output logic [31:0] rsp_key_hash
);

   logic [1:0]  alg_ff, alg_in;
   logic        fold_ff, fold_in;
   logic [31:0] hash_ff, hash_in;
   logic [31:0] blk_ff, blk_in;
   logic [31:0] cnt_ff, cnt_in;
   logic [31:0] w_ff, w_in;
   logic [31:0] out_ff, out_in;

   logic        murmur;
   logic        djb;
   logic [7:0]  b;
   logic [1:0]  pos;
   logic [31:0] blk_add;
   logic [31:0] fx;
   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [31:0] mul_p;

   assign murmur = (alg_ff == ALG_MURMUR);
   assign djb    = (alg_ff == ALG_DJB);
   assign pos    = cnt_ff[1:0];

   assign status.murmur   = murmur;
   assign status.blk_full = (pos == 2'd3);

   // ascii upper case to lower case when case fold is on
   assign b = (fold_ff && req_key_byte >= 8'h41 && req_key_byte <= 8'h5a)
              ? req_key_byte + 8'h20 : req_key_byte;

   assign blk_add = blk_ff | ({24'd0, b} << {pos, 3'b000});
   assign fx      = hash_ff ^ cnt_ff ^ (cmd.use_w ? w_ff : 32'd0);

   always_comb begin
      mul_a = hash_ff ^ {24'd0, b};
      mul_b = FNV_PRIME;
      case (cmd.op)
         OP_BYTE: begin
            if (murmur) begin
               mul_a = blk_add;
               mul_b = MM_C1;
            end
         end
         OP_KMIX2: begin
            mul_a = rotl15(w_ff);
            mul_b = MM_C2;
         end
         OP_HMIX: begin
            mul_a = rotl13(hash_ff ^ w_ff);
            mul_b = MM_H_MUL;
         end
         OP_TAIL1: begin
            mul_a = blk_ff;
            mul_b = MM_C1;
         end
         OP_FMIX1: begin
            mul_a = fx ^ (fx >> 16);
            mul_b = MM_F1;
         end
         OP_FMIX2: begin
            mul_a = hash_ff ^ (hash_ff >> 13);
            mul_b = MM_F2;
         end
         default: begin
            mul_a = hash_ff ^ {24'd0, b};
            mul_b = FNV_PRIME;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   always_comb begin
      alg_in  = alg_ff;
      fold_in = fold_ff;
      hash_in = hash_ff;
      blk_in  = blk_ff;
      cnt_in  = cnt_ff;
      w_in    = w_ff;
      out_in  = out_ff;
      case (cmd.op)
         OP_BYTE: begin
            cnt_in = cnt_ff + 32'd1;
            if (murmur) begin
               blk_in = blk_add;
               w_in   = mul_p;
            end else if (djb) begin
               hash_in = {hash_ff[26:0], 5'd0} + hash_ff + {24'd0, b};
            end else begin
               hash_in = mul_p;
            end
         end
         OP_KMIX2: begin
            w_in = mul_p;
         end
         OP_HMIX: begin
            hash_in = mul_p + MM_N;
            blk_in  = 32'd0;
         end
         OP_TAIL1: begin
            w_in = mul_p;
         end
         OP_FMIX1: begin
            hash_in = mul_p;
         end
         OP_FMIX2: begin
            hash_in = mul_p;
         end
         OP_FIN: begin
            out_in  = murmur ? (hash_ff ^ (hash_ff >> 16)) : hash_ff;
            hash_in = start_value(alg_ff);
            blk_in  = 32'd0;
            cnt_in  = 32'd0;
         end
         default: begin
         end
      endcase
      if (csr_write) begin
         case (csr_index)
            CSR_ALGORITHM: begin
               alg_in  = csr_data;
               hash_in = start_value(csr_data);
               blk_in  = 32'd0;
               cnt_in  = 32'd0;
            end
            CSR_FOLD_CASE: begin
               fold_in = csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alg_ff  <= ALG_FNV;
         fold_ff <= 1'b0;
         hash_ff <= FNV_BASIS;
         blk_ff  <= 32'd0;
         cnt_ff  <= 32'd0;
      end else begin
         alg_ff  <= alg_in;
         fold_ff <= fold_in;
         hash_ff <= hash_in;
         blk_ff  <= blk_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff   <= w_in;
      out_ff <= out_in;
   end

   assign rsp_key_hash = out_ff;

endmodule

@@ rtl/selectable_key_hash_engine_core.sv @@
// key hash engine top level: fnv-1a, djb2 or murmur3 32-bit over a byte stream
// a non-last byte keeps req_ready; a murmur byte closing a 4-byte block runs kmix2, hmix
// last byte: fnv, djb2 to fin; murmur via kmix2/hmix or tail1/tail2, fmix1, fmix2, fin
// the shared 32x32 multiplier is used once per cycle and sets the murmur step count
// a finished word waits in the output register while the next key streams in
// reset: synchronous, active high; fnv-1a selected, case fold off, hash state reset
`include "assert_macros.svh"

module selectable_key_hash_engine_core import skhe_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [1:0]  csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_key_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_key_hash
);

   cmd_type    cmd;
   status_type status;

   skhe_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .status        (status),
      .cmd           (cmd)
   );

   skhe_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_key_byte (req_key_byte),
      .cmd          (cmd),
      .status       (status),
      .rsp_key_hash (rsp_key_hash)
   );

   `ASSERT_NEXT(a_busy_after_last, clock, reset, req_valid && req_ready && req_last_byte, !req_ready)
   `ASSERT_SAME(a_word_after_finish, clock, reset, $rose(rsp_valid), !$past(req_ready))
   `ASSERT_NEXT(a_block_mix_busy, clock, reset, req_valid && req_ready && status.murmur && status.blk_full, !req_ready)

endmodule

@@ bench/selectable_key_hash_engine_core_tb.sv @@
// self-checking bench for the key hash engine: byte keys checked against an inline hash model
module selectable_key_hash_engine_core_tb import skhe_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] ALG_SPARE     = 2'd3;
   localparam logic [1:0] CSR_SPARE     = 2'd3;
   localparam int         SETTLE_CYCLES = 12;
   localparam int         STALL_LIMIT   = 2000;
   localparam int         HOLD_CYCLES   = 400;
   localparam int         HOLD_AFTER    = 80;
   localparam int         PHASES        = 10;
   localparam int         PHASE_BYTES   = 170;

   typedef struct packed {
      logic [7:0] key_byte;
      logic       last_byte;
   } key_word_type;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        csr_write     = 1'b0;
   logic [1:0]  csr_index     = CSR_ALGORITHM;
   logic [1:0]  csr_data      = 2'd0;
   logic        req_valid     = 1'b0;
   logic        req_ready;
   logic [7:0]  req_key_byte  = 8'd0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready     = 1'b0;
   logic [31:0] rsp_key_hash;

   key_word_type key_words[$];
   logic [31:0]  pending_hashes[$];

   // model state and register copy
   logic [1:0]  hash_alg   = ALG_FNV;
   logic        fold_on    = 1'b0;
   logic [31:0] acc_hash   = FNV_BASIS;
   logic [31:0] block_word = 32'd0;
   logic [31:0] key_len    = 32'd0;

   int unsigned words_sent   = 0;
   int unsigned bytes_taken  = 0;
   int unsigned hashes_seen  = 0;
   int unsigned fault_count  = 0;
   int unsigned quiet_cycles = 0;
   int unsigned hold_left    = 0;
   logic        hold_done    = 1'b0;
   logic        byte_accepted = 1'b0;

   selectable_key_hash_engine_core i_dut (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_key_byte  (req_key_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_key_hash  (rsp_key_hash)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic logic [31:0] initial_hash(input logic [1:0] alg);
      case (alg)
         ALG_DJB:    return DJB_START;
         ALG_MURMUR: return 32'd0;
         default:    return FNV_BASIS;
      endcase
   endfunction

   function automatic logic [31:0] mix_block(input logic [31:0] k);
      logic [31:0] m;
      m = k * MM_C1;
      m = {m[16:0], m[31:17]};
      return m * MM_C2;
   endfunction

   function automatic logic [31:0] avalanche(input logic [31:0] h);
      logic [31:0] a;
      a = h ^ (h >> 16);
      a = a * MM_F1;
      a = a ^ (a >> 13);
      a = a * MM_F2;
      return a ^ (a >> 16);
   endfunction

   task automatic hash_byte(input logic [7:0] kb, input logic last);
      logic [7:0]  b;
      logic [31:0] h;
      logic [1:0]  pos;
      b   = kb;
      h   = acc_hash;
      pos = key_len[1:0];
      if (fold_on && b >= 8'h41 && b <= 8'h5a) begin
         b = b + 8'h20;
      end
      case (hash_alg)
         ALG_DJB: begin
            h = h * 32'd33 + {24'd0, b};
         end
         ALG_MURMUR: begin
            block_word = block_word | ({24'd0, b} << (8 * pos));
            if (pos == 2'd3) begin
               h = h ^ mix_block(block_word);
               h = {h[18:0], h[31:19]};
               h = h * 32'd5 + MM_N;
               block_word = 32'd0;
            end
         end
         default: begin
            h = (h ^ {24'd0, b}) * FNV_PRIME;
         end
      endcase
      key_len = key_len + 32'd1;
      if (!last) begin
         acc_hash = h;
      end else begin
         if (hash_alg == ALG_MURMUR) begin
            if (key_len[1:0] != 2'd0) begin
               h = h ^ mix_block(block_word);
            end
            h = avalanche(h ^ key_len);
         end
         pending_hashes.push_back(h);
         acc_hash   = initial_hash(hash_alg);
         block_word = 32'd0;
         key_len    = 32'd0;
      end
   endtask

   function automatic void queue_word(input logic [7:0] b, input logic last);
      key_words.push_back({b, last});
   endfunction

   function automatic logic [7:0] pick_key_byte();
      int unsigned r;
      logic [7:0]  edges [6];
      edges = '{8'h40, 8'h5b, 8'h60, 8'h7b, 8'h00, 8'hff};
      r = $urandom_range(9);
      if (r < 4) return 8'h41 + 8'($urandom_range(25));
      if (r < 6) return 8'h61 + 8'($urandom_range(25));
      if (r == 6) return edges[$urandom_range(5)];
      return 8'($urandom_range(255));
   endfunction

   task automatic write_csr(input logic [1:0] index, input logic [1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      if (index == CSR_ALGORITHM) begin
         hash_alg   = value;
         acc_hash   = initial_hash(value);
         block_word = 32'd0;
         key_len    = 32'd0;
      end else if (index == CSR_FOLD_CASE) begin
         fold_on = value[0];
      end
      @(posedge clock);
   endtask

   task automatic settle();
      while (key_words.size() != 0 || req_valid) @(posedge clock);
      while (pending_hashes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // key byte sender
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || byte_accepted) begin
         if (key_words.size() != 0 &&
             ((words_sent >= 400 && words_sent < 800) || $urandom_range(99) >= 17)) begin
            req_valid     <= 1'b1;
            req_key_byte  <= key_words[0].key_byte;
            req_last_byte <= key_words[0].last_byte;
            key_words.delete(0);
            words_sent    <= words_sent + 1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // hash word receiver, with one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && hashes_seen >= HOLD_AFTER && req_valid) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= (hashes_seen >= 20 && hashes_seen < 70) || $urandom_range(99) >= 17;
      end
   end

   // prediction, checking and watchdog
   always @(posedge clock) begin
      byte_accepted <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            hash_byte(req_key_byte, req_last_byte);
            bytes_taken <= bytes_taken + 1;
         end
         if (rsp_valid && rsp_ready) begin
            hashes_seen <= hashes_seen + 1;
            if (pending_hashes.size() == 0) begin
               $error("key_hash: expected nothing, actual %h", rsp_key_hash);
               fault_count = fault_count + 1;
            end else begin
               if (rsp_key_hash !== pending_hashes[0]) begin
                  $error("key_hash: expected %h, actual %h", pending_hashes[0], rsp_key_hash);
                  fault_count = fault_count + 1;
               end
               pending_hashes.delete(0);
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("selectable_key_hash_engine_core: mismatch");
            $finish;
         end
      end
   end

   initial begin
      int unsigned phase;
      int unsigned phase_bytes;
      int unsigned key_no;
      int unsigned len;
      int unsigned split;
      int unsigned i;
      logic [1:0]  alg;
      logic [1:0]  fold_val;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed keys
      write_csr(CSR_SPARE, 2'b11);
      queue_word(8'h41, 1'b1);
      queue_word(8'h00, 1'b0);
      queue_word(8'hff, 1'b1);
      settle();
      write_csr(CSR_FOLD_CASE, 2'b01);
      queue_word(8'h41, 1'b0);
      queue_word(8'h5a, 1'b0);
      queue_word(8'h40, 1'b0);
      queue_word(8'h5b, 1'b1);
      settle();
      write_csr(CSR_ALGORITHM, ALG_DJB);
      queue_word(8'h61, 1'b0);
      queue_word(8'hff, 1'b1);
      settle();
      write_csr(CSR_ALGORITHM, ALG_MURMUR);
      queue_word(8'hff, 1'b1);
      queue_word(8'h00, 1'b0);
      queue_word(8'h01, 1'b0);
      queue_word(8'h02, 1'b0);
      queue_word(8'h03, 1'b1);
      queue_word(8'h5a, 1'b0);
      queue_word(8'h41, 1'b0);
      queue_word(8'hff, 1'b0);
      queue_word(8'h80, 1'b0);
      queue_word(8'h7f, 1'b1);
      // key cut short by an algorithm change
      queue_word(8'h12, 1'b0);
      queue_word(8'h34, 1'b0);
      queue_word(8'h56, 1'b0);
      settle();
      write_csr(CSR_ALGORITHM, ALG_SPARE);
      queue_word(8'h00, 1'b1);
      settle();

      // random keys, one algorithm per phase; case fold set per phase and may be toggled part way through a key
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase % 5)
            0:       alg = ALG_FNV;
            1:       alg = ALG_DJB;
            3:       alg = ALG_SPARE;
            default: alg = ALG_MURMUR;
         endcase
         fold_val = 2'($urandom_range(3));
         if (phase % 2 == 1) begin
            write_csr(CSR_ALGORITHM, alg);
            write_csr(CSR_FOLD_CASE, fold_val);
         end else begin
            write_csr(CSR_FOLD_CASE, fold_val);
            write_csr(CSR_ALGORITHM, alg);
         end
         phase_bytes = 0;
         key_no = 0;
         while (phase_bytes < PHASE_BYTES) begin
            len = ($urandom_range(99) < 85) ? $urandom_range(12, 1) : $urandom_range(48, 13);
            split = (key_no == 2 && len > 1) ? $urandom_range(len - 1, 1) : 0;
            for (i = 1; i <= len; i++) begin
               queue_word(pick_key_byte(), i == len);
               // fold toggled part way through a key
               if (i == split) begin
                  settle();
                  fold_val = fold_val ^ 2'b01;
                  write_csr(CSR_FOLD_CASE, fold_val);
               end
            end
            phase_bytes += len;
            key_no++;
         end
         if (phase != PHASES - 1 && $urandom_range(2) == 0) begin
            len = $urandom_range(6, 1);
            for (i = 0; i < len; i++) begin
               queue_word(pick_key_byte(), 1'b0);
            end
         end
         settle();
      end

      $display("keys under fnv-1a, djb2, murmur3 and the spare code, fold on and off, some abandoned");
      $display("%0d key bytes taken, %0d hash words checked", bytes_taken, hashes_seen);
      if (fault_count == 0) begin
         $display("selectable_key_hash_engine_core: match");
      end else begin
         $display("selectable_key_hash_engine_core: mismatch");
      end
      $finish;
   end

endmodule
